// File: rtl/core/tmlcf_pkg.sv
// Shared types and constants for the trimmed-mean load-cell filter.
// Holds register codes, fixed field widths, the controller state and
// the command/status structs. No dependencies.
package tmlcf_pkg;

    // Fixed field widths
    localparam int TARE_W    = 24;
    localparam int GAIN_W    = 41;
    localparam int GAIN_FRAC = 24;
    localparam int WEIGHT_W  = 21;
    localparam int G_LO_W    = 21;   // low slice of gain per multiply pass

    localparam int WEIGHT_LIMIT = 999999;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_TARE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 41'h0_0100_0000;  // 1.0 in Q24

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_DIV,
        ST_NET,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ACC,
        ST_OUT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic prep;
        logic div;
        logic net;
        logic mul_lo;
        logic mul_hi;
        logic acc;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic scan_last;
        logic div_last;
        logic out_free;
    } t_stat;

endpackage

// File: rtl/core/tmlcf_sample_if.sv
// Input channel carrying one raw converter sample per transfer.
// Depends on nothing; width set by SAMPLE_BITS.
interface tmlcf_sample_if #(
    parameter int SAMPLE_BITS = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// File: rtl/core/tmlcf_result_if.sv
// Output channel carrying one filter result per transfer.
// Depends on tmlcf_pkg for the weight width.
interface tmlcf_result_if #(
    parameter int SAMPLE_BITS = 24,
    parameter int NET_BITS    = 25
);
    logic                                   valid;
    logic                                   ready;
    logic signed [SAMPLE_BITS-1:0]          filtered;
    logic signed [NET_BITS-1:0]             net;
    logic signed [tmlcf_pkg::WEIGHT_W-1:0]  weight_centi;
    logic                                   window_full;

    modport source (output valid, output filtered, output net, output weight_centi,
                    output window_full, input ready);
    modport sink   (input valid, input filtered, input net, input weight_centi,
                    input window_full, output ready);
endinterface

// File: rtl/core/tmlcf_ctrl.sv
// Sequencer for the filter: steps one sample through scan, divide,
// net, multiply and output. Depends on tmlcf_pkg (t_state, t_cmd, t_stat).
module tmlcf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  tmlcf_pkg::t_stat i_stat,
    output tmlcf_pkg::t_cmd  o_cmd
);

    tmlcf_pkg::t_state r_state;
    tmlcf_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmlcf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tmlcf_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = tmlcf_pkg::ST_SCAN;
            end
            tmlcf_pkg::ST_SCAN: begin
                if (i_stat.scan_last) n_state = tmlcf_pkg::ST_PREP;
            end
            tmlcf_pkg::ST_PREP:   n_state = tmlcf_pkg::ST_DIV;
            tmlcf_pkg::ST_DIV: begin
                if (i_stat.div_last) n_state = tmlcf_pkg::ST_NET;
            end
            tmlcf_pkg::ST_NET:    n_state = tmlcf_pkg::ST_MUL_LO;
            tmlcf_pkg::ST_MUL_LO: n_state = tmlcf_pkg::ST_MUL_HI;
            tmlcf_pkg::ST_MUL_HI: n_state = tmlcf_pkg::ST_ACC;
            tmlcf_pkg::ST_ACC:    n_state = tmlcf_pkg::ST_OUT;
            tmlcf_pkg::ST_OUT: begin
                if (i_stat.out_free) n_state = tmlcf_pkg::ST_IDLE;
            end
            default:              n_state = tmlcf_pkg::ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            tmlcf_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            tmlcf_pkg::ST_SCAN:   o_cmd.scan   = 1'b1;
            tmlcf_pkg::ST_PREP:   o_cmd.prep   = 1'b1;
            tmlcf_pkg::ST_DIV:    o_cmd.div    = 1'b1;
            tmlcf_pkg::ST_NET:    o_cmd.net    = 1'b1;
            tmlcf_pkg::ST_MUL_LO: o_cmd.mul_lo = 1'b1;
            tmlcf_pkg::ST_MUL_HI: o_cmd.mul_hi = 1'b1;
            tmlcf_pkg::ST_ACC:    o_cmd.acc    = 1'b1;
            tmlcf_pkg::ST_OUT:    o_cmd.out_load = i_stat.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/core/tmlcf_dpath.sv
// Filter datapath: sample window, sum/min/max scan, radix-2 divider,
// tare subtract, split gain multiply, saturation and output register.
// Depends on tmlcf_pkg (widths, register codes, t_cmd, t_stat).
module tmlcf_dpath #(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 24,
    parameter int NET_BITS    = 25
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tmlcf_pkg::t_cmd                       i_cmd,
    output tmlcf_pkg::t_stat                      o_stat,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    input  logic                                  i_cfg_we,
    input  logic [tmlcf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tmlcf_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]         o_filtered,
    output logic signed [NET_BITS-1:0]            o_net,
    output logic signed [tmlcf_pkg::WEIGHT_W-1:0] o_weight_centi,
    output logic                                  o_window_full
);

    localparam int SB     = SAMPLE_BITS;
    localparam int FC_W   = $clog2(WINDOW + 1);
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int SUM_W  = SB + FC_W;
    localparam int CNT_W  = $clog2(SB);
    localparam int GW     = tmlcf_pkg::GAIN_W;
    localparam int GLO    = tmlcf_pkg::G_LO_W;
    localparam int WW     = tmlcf_pkg::WEIGHT_W;
    localparam int FRAC   = tmlcf_pkg::GAIN_FRAC;
    localparam int PP_W   = NET_BITS + GLO;
    localparam int PROD_W = NET_BITS + GW;

    localparam logic [PROD_W-1:0] SAT_LIM =
        PROD_W'(64'(tmlcf_pkg::WEIGHT_LIMIT + 1)) << FRAC;

    // Configuration registers
    logic signed [tmlcf_pkg::TARE_W-1:0] r_tare;
    logic [GW-1:0]                       r_gain;

    // Window and scan state
    logic signed [SB-1:0]    r_win [WINDOW];
    logic [FC_W-1:0]         r_fill;
    logic [IDX_W-1:0]        r_idx;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SB-1:0]    r_max;
    logic signed [SB-1:0]    r_min;

    // Divider state
    logic                    r_neg;
    logic [FC_W-1:0]         r_rem;
    logic [SB-1:0]           r_q;
    logic [FC_W-1:0]         r_div;
    logic [CNT_W-1:0]        r_cnt;

    // Scaling state
    logic signed [SB-1:0]       r_filt;
    logic signed [NET_BITS-1:0] r_net;
    logic [NET_BITS-1:0]        r_mag;
    logic                       r_wneg;
    logic [PP_W-1:0]            r_pp;
    logic [PROD_W-1:0]          r_prod;

    // Output register
    logic                       r_o_valid;
    logic signed [SB-1:0]       r_o_filt;
    logic signed [NET_BITS-1:0] r_o_net;
    logic signed [WW-1:0]       r_o_weight;
    logic                       r_o_full;

    logic                       w_full;
    logic signed [SB-1:0]       w_rd;
    logic signed [SUM_W-1:0]    w_dvd;
    logic [SUM_W-1:0]           w_dmag;
    logic [FC_W:0]              w_shift;
    logic [FC_W:0]              w_diff;
    logic                       w_ge;
    logic signed [SB-1:0]       w_filt;
    logic signed [NET_BITS-1:0] w_net;
    logic                       w_sat;
    logic [WW-1:0]              w_wmag;
    logic [WW-1:0]              w_weight;

    assign w_full = (r_fill == FC_W'(WINDOW));
    assign w_rd   = r_win[r_idx];

    // Config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tare <= '0;
            r_gain <= tmlcf_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == tmlcf_pkg::CFG_TARE) begin
                r_tare <= i_cfg_data[tmlcf_pkg::TARE_W-1:0];
            end else if (i_cfg_idx == tmlcf_pkg::CFG_GAIN) begin
                r_gain <= i_cfg_data[GW-1:0];
            end
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.load && !w_full) begin
            r_fill <= r_fill + FC_W'(1);
        end
    end

    // Window: append while filling, shift once full
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (!w_full) begin
                r_win[r_fill[IDX_W-1:0]] <= i_sample;
            end else begin
                for (int i = 0; i < WINDOW - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[WINDOW-1] <= i_sample;
            end
        end
    end

    // Scan: one entry per cycle into sum, max and min
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= '0;
            r_sum <= '0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + IDX_W'(1);
            r_sum <= r_sum + SUM_W'(w_rd);
            if (r_idx == '0) begin
                r_max <= w_rd;
                r_min <= w_rd;
            end else begin
                if (w_rd > r_max) r_max <= w_rd;
                if (w_rd < r_min) r_min <= w_rd;
            end
        end
    end

    // Dividend and one quotient bit per step
    assign w_dvd   = w_full ? (r_sum - SUM_W'(r_max) - SUM_W'(r_min)) : r_sum;
    assign w_dmag  = w_dvd[SUM_W-1] ? SUM_W'(-w_dvd) : SUM_W'(w_dvd);
    assign w_shift = {r_rem, r_q[SB-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_diff  = w_shift - {1'b0, r_div};

    // The mean fits the sample range, so the bits above SB start the remainder
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_neg <= w_dvd[SUM_W-1];
            r_rem <= w_dmag[SUM_W-1:SB];
            r_q   <= w_dmag[SB-1:0];
            r_div <= w_full ? FC_W'(WINDOW - 2) : r_fill;
            r_cnt <= '0;
        end else if (i_cmd.div) begin
            r_rem <= w_ge ? w_diff[FC_W-1:0] : w_shift[FC_W-1:0];
            r_q   <= {r_q[SB-2:0], w_ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // Signed mean and net value
    assign w_filt = r_neg ? -$signed(r_q) : $signed(r_q);
    assign w_net  = NET_BITS'(w_filt) - NET_BITS'(r_tare);

    // Net, magnitude and the two gain passes
    always_ff @(posedge i_clk) begin
        if (i_cmd.net) begin
            r_filt <= w_filt;
            r_net  <= w_net;
            r_wneg <= w_net[NET_BITS-1];
            r_mag  <= w_net[NET_BITS-1] ? NET_BITS'(-w_net) : NET_BITS'(w_net);
        end
        if (i_cmd.mul_lo) begin
            r_pp <= PP_W'(r_mag) * PP_W'(r_gain[GLO-1:0]);
        end else if (i_cmd.mul_hi) begin
            r_prod <= PROD_W'(r_pp);
            r_pp   <= PP_W'(r_mag) * PP_W'(r_gain[GW-1:GLO]);
        end else if (i_cmd.acc) begin
            r_prod <= r_prod + (PROD_W'(r_pp) << GLO);
        end
    end

    // Saturate and restore the sign
    assign w_sat    = (r_prod >= SAT_LIM);
    assign w_wmag   = w_sat ? WW'(tmlcf_pkg::WEIGHT_LIMIT)
                            : {1'b0, r_prod[FRAC+WW-2:FRAC]};
    assign w_weight = r_wneg ? (-w_wmag) : w_wmag;

    // Output register, held until transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_filt   <= r_filt;
            r_o_net    <= r_net;
            r_o_weight <= w_weight;
            r_o_full   <= w_full;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_filtered     = r_o_filt;
    assign o_net          = r_o_net;
    assign o_weight_centi = r_o_weight;
    assign o_window_full  = r_o_full;

    // Status to the sequencer
    assign o_stat.scan_last = (FC_W'(r_idx) == (r_fill - FC_W'(1)));
    assign o_stat.div_last  = (r_cnt == CNT_W'(SB - 1));
    assign o_stat.out_free  = !r_o_valid || i_out_ready;

endmodule

// File: rtl/core/trimmed_mean_load_cell_filter_unit.sv
// Trimmed-mean load-cell filter, top level.
// From input transfer to result valid, the sample window is scanned one entry per step,
// divided one quotient bit per step, then netted, scaled by the gain and registered.
// A new sample is taken only once the previous result is loaded into the output register,
// and that load waits while the output register is still held by the sink.
// Reset (synchronous, active low): empty window, tare 0, gain 1.0, no result.
module trimmed_mean_load_cell_filter_unit #(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 24,
    parameter int NET_BITS    = 25
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    tmlcf_sample_if.sink                        i_in,
    tmlcf_result_if.source                      o_out,
    input  logic                                i_cfg_we,
    input  logic [tmlcf_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [tmlcf_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    tmlcf_pkg::t_cmd  w_cmd;
    tmlcf_pkg::t_stat w_stat;

    // Sequencer
    tmlcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath
    tmlcf_dpath #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS),
        .NET_BITS    (NET_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_sample       (i_in.sample),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_filtered     (o_out.filtered),
        .o_net          (o_out.net),
        .o_weight_centi (o_out.weight_centi),
        .o_window_full  (o_out.window_full)
    );

endmodule
